FILE: src/u8cp_pkg.sv
// Package for the UTF-8 / CP437 transcoder: table, widths and helper functions.
// No dependencies.
package u8cp_pkg;

    localparam int CpW = 21;
    localparam logic [7:0] Unmapped = 8'd63;

    typedef logic [CpW-1:0] cp_t;

    typedef struct packed {
        logic [2:0] bytes_used;
        logic [7:0] cp437_byte;
        cp_t        code_point;
    } result_t;

    // Code point of a CP437 byte of the upper half
    function automatic logic [15:0] cp437_hi(input logic [6:0] idx);
        logic [15:0] r;
        case (idx)
            7'd0: r = 16'h00C7; 7'd1: r = 16'h00FC; 7'd2: r = 16'h00E9; 7'd3: r = 16'h00E2;
            7'd4: r = 16'h00E4; 7'd5: r = 16'h00E0; 7'd6: r = 16'h00E5; 7'd7: r = 16'h00E7;
            7'd8: r = 16'h00EA; 7'd9: r = 16'h00EB; 7'd10: r = 16'h00E8; 7'd11: r = 16'h00EF;
            7'd12: r = 16'h00EE; 7'd13: r = 16'h00EC; 7'd14: r = 16'h00C4; 7'd15: r = 16'h00C5;
            7'd16: r = 16'h00C9; 7'd17: r = 16'h00E6; 7'd18: r = 16'h00C6; 7'd19: r = 16'h00F4;
            7'd20: r = 16'h00F6; 7'd21: r = 16'h00F2; 7'd22: r = 16'h00FB; 7'd23: r = 16'h00F9;
            7'd24: r = 16'h00FF; 7'd25: r = 16'h00D6; 7'd26: r = 16'h00DC; 7'd27: r = 16'h00A2;
            7'd28: r = 16'h00A3; 7'd29: r = 16'h00A5; 7'd30: r = 16'h20A7; 7'd31: r = 16'h0192;
            7'd32: r = 16'h00E1; 7'd33: r = 16'h00ED; 7'd34: r = 16'h00F3; 7'd35: r = 16'h00FA;
            7'd36: r = 16'h00F1; 7'd37: r = 16'h00D1; 7'd38: r = 16'h00AA; 7'd39: r = 16'h00BA;
            7'd40: r = 16'h00BF; 7'd41: r = 16'h2310; 7'd42: r = 16'h00AC; 7'd43: r = 16'h00BD;
            7'd44: r = 16'h00BC; 7'd45: r = 16'h00A1; 7'd46: r = 16'h00AB; 7'd47: r = 16'h00BB;
            7'd48: r = 16'h2591; 7'd49: r = 16'h2592; 7'd50: r = 16'h2593; 7'd51: r = 16'h2502;
            7'd52: r = 16'h2524; 7'd53: r = 16'h2561; 7'd54: r = 16'h2562; 7'd55: r = 16'h2556;
            7'd56: r = 16'h2555; 7'd57: r = 16'h2563; 7'd58: r = 16'h2551; 7'd59: r = 16'h2557;
            7'd60: r = 16'h255D; 7'd61: r = 16'h255C; 7'd62: r = 16'h255B; 7'd63: r = 16'h2510;
            7'd64: r = 16'h2514; 7'd65: r = 16'h2534; 7'd66: r = 16'h252C; 7'd67: r = 16'h251C;
            7'd68: r = 16'h2500; 7'd69: r = 16'h253C; 7'd70: r = 16'h255E; 7'd71: r = 16'h255F;
            7'd72: r = 16'h255A; 7'd73: r = 16'h2554; 7'd74: r = 16'h2569; 7'd75: r = 16'h2566;
            7'd76: r = 16'h2560; 7'd77: r = 16'h2550; 7'd78: r = 16'h256C; 7'd79: r = 16'h2567;
            7'd80: r = 16'h2568; 7'd81: r = 16'h2564; 7'd82: r = 16'h2565; 7'd83: r = 16'h2559;
            7'd84: r = 16'h2558; 7'd85: r = 16'h2552; 7'd86: r = 16'h2553; 7'd87: r = 16'h256B;
            7'd88: r = 16'h256A; 7'd89: r = 16'h2518; 7'd90: r = 16'h250C; 7'd91: r = 16'h2588;
            7'd92: r = 16'h2584; 7'd93: r = 16'h258C; 7'd94: r = 16'h2590; 7'd95: r = 16'h2580;
            7'd96: r = 16'h03B1; 7'd97: r = 16'h00DF; 7'd98: r = 16'h0393; 7'd99: r = 16'h03C0;
            7'd100: r = 16'h03A3; 7'd101: r = 16'h03C3; 7'd102: r = 16'h00B5; 7'd103: r = 16'h03C4;
            7'd104: r = 16'h03A6; 7'd105: r = 16'h0398; 7'd106: r = 16'h03A9; 7'd107: r = 16'h03B4;
            7'd108: r = 16'h221E; 7'd109: r = 16'h03C6; 7'd110: r = 16'h03B5; 7'd111: r = 16'h2229;
            7'd112: r = 16'h2261; 7'd113: r = 16'h00B1; 7'd114: r = 16'h2265; 7'd115: r = 16'h2264;
            7'd116: r = 16'h2320; 7'd117: r = 16'h2321; 7'd118: r = 16'h00F7; 7'd119: r = 16'h2248;
            7'd120: r = 16'h00B0; 7'd121: r = 16'h2219; 7'd122: r = 16'h00B7; 7'd123: r = 16'h221A;
            7'd124: r = 16'h207F; 7'd125: r = 16'h00B2; 7'd126: r = 16'h25A0; default: r = 16'h00A0;
        endcase
        return r;
    endfunction

    // Reverse match: code point to CP437 byte, '?' when absent
    function automatic logic [7:0] to_cp437(input cp_t cp);
        logic [7:0] r;
        r = Unmapped;
        if (cp < cp_t'(128)) begin
            r = cp[7:0];
        end else if (cp[CpW-1:16] == '0) begin
            for (int i = 0; i < 128; i++) begin
                if (cp437_hi(7'(i)) == cp[15:0]) r = 8'(i + 128);
            end
        end
        return r;
    endfunction

endpackage

FILE: src/u8cp_decoder.sv
// Combinational UTF-8 / CP437 step: next sequence state and the result of one byte.
// Depends on u8cp_pkg.
module u8cp_decoder (
    input  logic               fmt,
    input  logic [7:0]         in_byte,
    input  logic [1:0]         rem,
    input  logic [2:0]         seq_len,
    input  u8cp_pkg::cp_t      partial,
    output logic [1:0]         rem_next,
    output logic [2:0]         seq_len_next,
    output u8cp_pkg::cp_t      partial_next,
    output logic               emit,
    output u8cp_pkg::result_t  res
);
    import u8cp_pkg::*;

    cp_t        cp;
    cp_t        shifted;
    cp_t        minv;
    logic [2:0] used;

    assign shifted = {partial[CpW-7:0], in_byte[5:0]};

    always_comb begin
        rem_next     = rem;
        seq_len_next = seq_len;
        partial_next = partial;
        emit         = 1'b0;
        cp           = '0;
        used         = 3'd1;
        minv         = cp_t'(65536);
        if (fmt) begin
            emit = 1'b1;
            cp   = in_byte[7] ? cp_t'(cp437_hi(in_byte[6:0])) : cp_t'(in_byte);
        end else if (rem != 2'd0) begin
            // shift in continuation payload
            rem_next = rem - 2'd1;
            if (rem == 2'd1) begin
                emit = 1'b1;
                if (seq_len == 3'd2) minv = cp_t'(128);
                else if (seq_len == 3'd3) minv = cp_t'(2048);
                cp   = (shifted < minv) ? '0 : shifted;
                used = seq_len;
                seq_len_next = 3'd0;
                partial_next = '0;
            end else begin
                partial_next = shifted;
            end
        end else if (!in_byte[7]) begin
            emit = 1'b1;
            cp   = cp_t'(in_byte);
        end else if (in_byte[7:5] == 3'b110) begin
            partial_next = cp_t'(in_byte[4:0]);
            rem_next = 2'd1; seq_len_next = 3'd2;
        end else if (in_byte[7:4] == 4'b1110) begin
            partial_next = cp_t'(in_byte[3:0]);
            rem_next = 2'd2; seq_len_next = 3'd3;
        end else if (in_byte[7:3] == 5'b11110) begin
            partial_next = cp_t'(in_byte[2:0]);
            rem_next = 2'd3; seq_len_next = 3'd4;
        end else begin
            emit = 1'b1;
        end
        res.code_point = cp;
        res.cp437_byte = fmt ? in_byte : to_cp437(cp);
        res.bytes_used = used;
    end
endmodule

FILE: src/utf8_cp437_transcoder_unit.sv
// Top level of the UTF-8 / CP437 transcoder: input register, decoder, result register.
// Depends on u8cp_pkg and u8cp_decoder.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | in_byte[7:0]
//  m_axis  | out | code_point[20:0], cp437_byte[28:21], bytes_used[31:29]
//  cfg     | in  | input_format (cfg_wr_en, cfg_wr_data)
//
// One byte per cycle unless the result stalls; a byte enters the input register, is
// decoded by the combinational step and its character lands in the result register.
// A result is valid once its last byte has gone through both registers.
// aresetn is synchronous, active low; it clears the format and sequence state.
// A stalled result holds only the stages behind it; the input side keeps going
// while either stage has room.
module utf8_cp437_transcoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // code_point, cp437_byte, bytes_used
);
    import u8cp_pkg::*;

    logic       fmt_reg;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic [1:0] rem_reg, rem_next;
    logic [2:0] seq_len_reg, seq_len_next;
    cp_t        partial_reg, partial_next;
    logic       out_vld_reg;
    result_t    out_reg, res;
    logic       emit, advance;

    // decode stage may move when the result register is free or draining
    assign advance       = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !in_vld_reg || advance;

    u8cp_decoder u_dec (
        .fmt(fmt_reg), .in_byte(in_byte_reg), .rem(rem_reg), .seq_len(seq_len_reg),
        .partial(partial_reg), .rem_next(rem_next), .seq_len_next(seq_len_next),
        .partial_next(partial_next), .emit(emit), .res(res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) in_byte_reg <= s_axis_tdata;
    end

    // format and sequence state; a write abandons the open sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg     <= 1'b0;
            rem_reg     <= 2'd0;
            seq_len_reg <= 3'd0;
            partial_reg <= '0;
        end else if (cfg_wr_en) begin
            fmt_reg     <= cfg_wr_data;
            rem_reg     <= 2'd0;
            seq_len_reg <= 3'd0;
            partial_reg <= '0;
        end else if (in_vld_reg && advance) begin
            rem_reg     <= rem_next;
            seq_len_reg <= seq_len_next;
            partial_reg <= partial_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg && emit;
        end
        if (advance && in_vld_reg && emit) out_reg <= res;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    // a stalled result must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // bytes_used stays within one to four
    a_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_reg.bytes_used >= 3'd1 && out_reg.bytes_used <= 3'd4))
        else $error("bytes_used out of range");
    // an open sequence exists only in UTF-8 mode
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_reg |-> rem_reg == 2'd0)
        else $error("sequence open in CP437 mode");
`endif
endmodule

FILE: tb/tb_utf8_cp437_transcoder_unit.sv
// Testbench for utf8_cp437_transcoder_unit: byte streams in UTF-8 and CP437 mode,
// checked against an in-bench predictor. Depends on u8cp_pkg and the transcoder RTL.
module tb_utf8_cp437_transcoder_unit;
    import u8cp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles = 8;
    localparam logic FmtUtf8 = 1'b0;
    localparam logic FmtCp437 = 1'b1;
    localparam logic [7:0] QMark = 8'd63;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    utf8_cp437_transcoder_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // in_byte
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)    // code_point, cp437_byte, bytes_used
    );

    // Predictor state
    logic        fmt;
    logic [1:0]  left_cnt;
    logic [2:0]  seq_len;
    logic [20:0] acc_cp;
    result_t     chars_due[$];

    int errors = 0;
    int idle_send = 0;
    int idle_recv = 0;
    bit hold_recv = 0;
    int quiet = 0;

    // Directed rows: byte, expected-known flag, expected char
    typedef struct {
        logic [7:0] b;
        bit         known;
        result_t    r;
    } row_t;

    row_t rows[$];

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] hi_table(input int i);
        logic [15:0] t [128] = '{
            16'h00C7,16'h00FC,16'h00E9,16'h00E2,16'h00E4,16'h00E0,16'h00E5,16'h00E7,
            16'h00EA,16'h00EB,16'h00E8,16'h00EF,16'h00EE,16'h00EC,16'h00C4,16'h00C5,
            16'h00C9,16'h00E6,16'h00C6,16'h00F4,16'h00F6,16'h00F2,16'h00FB,16'h00F9,
            16'h00FF,16'h00D6,16'h00DC,16'h00A2,16'h00A3,16'h00A5,16'h20A7,16'h0192,
            16'h00E1,16'h00ED,16'h00F3,16'h00FA,16'h00F1,16'h00D1,16'h00AA,16'h00BA,
            16'h00BF,16'h2310,16'h00AC,16'h00BD,16'h00BC,16'h00A1,16'h00AB,16'h00BB,
            16'h2591,16'h2592,16'h2593,16'h2502,16'h2524,16'h2561,16'h2562,16'h2556,
            16'h2555,16'h2563,16'h2551,16'h2557,16'h255D,16'h255C,16'h255B,16'h2510,
            16'h2514,16'h2534,16'h252C,16'h251C,16'h2500,16'h253C,16'h255E,16'h255F,
            16'h255A,16'h2554,16'h2569,16'h2566,16'h2560,16'h2550,16'h256C,16'h2567,
            16'h2568,16'h2564,16'h2565,16'h2559,16'h2558,16'h2552,16'h2553,16'h256B,
            16'h256A,16'h2518,16'h250C,16'h2588,16'h2584,16'h258C,16'h2590,16'h2580,
            16'h03B1,16'h00DF,16'h0393,16'h03C0,16'h03A3,16'h03C3,16'h00B5,16'h03C4,
            16'h03A6,16'h0398,16'h03A9,16'h03B4,16'h221E,16'h03C6,16'h03B5,16'h2229,
            16'h2261,16'h00B1,16'h2265,16'h2264,16'h2320,16'h2321,16'h00F7,16'h2248,
            16'h00B0,16'h2219,16'h00B7,16'h221A,16'h207F,16'h00B2,16'h25A0,16'h00A0};
        return t[i];
    endfunction

    function automatic result_t make_char(input logic [20:0] cp, input logic [2:0] used);
        result_t r;
        r.code_point = cp;
        r.bytes_used = used;
        r.cp437_byte = QMark;
        if (cp < 21'd128) begin
            r.cp437_byte = cp[7:0];
        end else begin
            for (int i = 0; i < 128; i++)
                if ({5'd0, hi_table(i)} == cp) r.cp437_byte = 8'(i + 128);
        end
        return r;
    endfunction

    // Advance the predictor by one byte; queue a character if one completes
    task automatic transcode_byte(input logic [7:0] b);
        logic [20:0] floor_cp;
        if (fmt == FmtCp437) begin
            chars_due.push_back(make_char(b[7] ? {5'd0, hi_table(b[6:0])} : {13'd0, b}, 3'd1));
        end else if (left_cnt != 0) begin
            acc_cp = {acc_cp[14:0], b[5:0]};
            left_cnt = left_cnt - 2'd1;
            if (left_cnt == 0) begin
                floor_cp = (seq_len == 3'd2) ? 21'd128 : (seq_len == 3'd3) ? 21'd2048 : 21'd65536;
                chars_due.push_back(make_char(acc_cp < floor_cp ? 21'd0 : acc_cp, seq_len));
                seq_len = 0;
                acc_cp = 0;
            end
        end else if (!b[7]) begin
            chars_due.push_back(make_char({13'd0, b}, 3'd1));
        end else if (b[7:5] == 3'b110) begin
            acc_cp = {16'd0, b[4:0]}; left_cnt = 2'd1; seq_len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            acc_cp = {17'd0, b[3:0]}; left_cnt = 2'd2; seq_len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            acc_cp = {18'd0, b[2:0]}; left_cnt = 2'd3; seq_len = 3'd4;
        end else begin
            chars_due.push_back(make_char(21'd0, 3'd1));
        end
    endtask

    // Offer one byte and wait for its transfer; valid stays up for the next byte
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_send) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        transcode_byte(b);
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Drop valid, wait for the block to drain, then write the format register
    task automatic set_format(input logic f);
        s_axis_tvalid <= 1'b0;
        while (chars_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= f;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fmt = f;
        left_cnt = 0; seq_len = 0; acc_cp = 0;
    endtask

    // Random UTF-8 sequence, mostly well-formed, some broken or noise
    task automatic send_utf8_sequence();
        int kind, n;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 15) begin
            send_byte(8'($urandom));
            return;
        end
        n = $urandom_range(1, 4);
        case (n)
            1: lead = {1'b0, 7'($urandom)};
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        send_byte(lead);
        for (int i = 1; i < n; i++)
            send_byte(kind < 25 ? 8'($urandom) : {2'b10, 6'($urandom)});
    endtask

    function automatic void add_row(input logic [7:0] b, input bit known,
                                    input logic [20:0] cp, input logic [7:0] c,
                                    input logic [2:0] u);
        row_t r;
        r.b = b; r.known = known;
        r.r.code_point = cp; r.r.cp437_byte = c; r.r.bytes_used = u;
        rows.push_back(r);
    endfunction

    // Receiver ready with random idling and a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= !hold_recv && ($urandom_range(99) >= idle_recv);
    end

    // Compare each result transfer with the oldest expected character
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata);
            if (chars_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected character %h", m_axis_tdata);
            end else begin
                want = chars_due.pop_front();
                if (got.code_point !== want.code_point || got.cp437_byte !== want.cp437_byte ||
                    got.bytes_used !== want.bytes_used) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp cp=%h c=%h u=%0d got cp=%h c=%h u=%0d",
                                 want.code_point, want.cp437_byte, want.bytes_used,
                                 got.code_point, got.cp437_byte, got.bytes_used);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en
            || hold_recv) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int waited;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        fmt = FmtUtf8; left_cnt = 0; seq_len = 0; acc_cp = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows in UTF-8 mode after reset
        add_row(8'h00, 1, 21'h0, 8'h00, 3'd1);
        add_row(8'h7F, 1, 21'h7F, 8'h7F, 3'd1);
        add_row(8'h80, 1, 21'h0, 8'h00, 3'd1);   // stray continuation as lead
        add_row(8'hF8, 1, 21'h0, 8'h00, 3'd1);   // invalid lead
        add_row(8'hFF, 1, 21'h0, 8'h00, 3'd1);
        add_row(8'hC3, 0, 0, 0, 0);
        add_row(8'hA9, 0, 0, 0, 0);              // U+00E9
        add_row(8'hC1, 0, 0, 0, 0);
        add_row(8'hBF, 1, 21'h0, 8'h00, 3'd2);   // overlong two-byte
        add_row(8'hE2, 0, 0, 0, 0);
        add_row(8'h95, 0, 0, 0, 0);
        add_row(8'hA7, 0, 0, 0, 0);              // U+2567
        add_row(8'hE0, 0, 0, 0, 0);
        add_row(8'h9F, 0, 0, 0, 0);
        add_row(8'hBF, 1, 21'h0, 8'h00, 3'd3);   // overlong three-byte
        add_row(8'hF0, 0, 0, 0, 0);
        add_row(8'h8F, 0, 0, 0, 0);
        add_row(8'hBF, 0, 0, 0, 0);
        add_row(8'hBF, 1, 21'h0, 8'h00, 3'd4);   // overlong four-byte
        add_row(8'hF7, 0, 0, 0, 0);
        add_row(8'hFF, 0, 0, 0, 0);              // continuation bits unchecked
        add_row(8'hFF, 0, 0, 0, 0);
        add_row(8'hFF, 1, 21'h1FFFFF, QMark, 3'd4);
        foreach (rows[i]) begin
            send_byte(rows[i].b);
            if (rows[i].known) chars_due[chars_due.size()-1] = rows[i].r;
        end

        // Open a sequence, then abandon it by a register write
        send_byte(8'hE2);
        set_format(FmtCp437);
        send_byte(8'h41);
        send_byte(8'h80);
        send_byte(8'hCF);
        send_byte(8'hFF);
        set_format(FmtUtf8);

        // Random phases across idling profiles and both formats
        for (int ph = 0; ph < 6; ph++) begin
            idle_send = (ph < 2) ? 37 : (ph < 4) ? 78 : 0;
            idle_recv = (ph < 2) ? 78 : (ph < 4) ? 37 : 0;
            set_format((ph % 2) ? FmtCp437 : FmtUtf8);
            if (ph == 4) begin
                // Long receiver hold-off while bytes keep coming
                fork
                    begin
                        hold_recv = 1;
                        waited = 0;
                        while (waited < 60) begin @(posedge aclk); waited++; end
                        hold_recv = 0;
                    end
                    begin
                        for (int k = 0; k < 20; k++) send_byte(8'($urandom));
                    end
                join
            end
            if (ph % 2) begin
                for (int k = 0; k < 200; k++) send_byte(8'($urandom));
            end else begin
                for (int k = 0; k < 180; k++) send_utf8_sequence();
            end
        end

        // Drain with a bound, then report
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (chars_due.size() != 0 && waited < WatchdogLimit) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0 && chars_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

FILE: sim.f
src/u8cp_pkg.sv
src/u8cp_decoder.sv
src/utf8_cp437_transcoder_unit.sv
tb/tb_utf8_cp437_transcoder_unit.sv
